// File: src/lrs_pkg.sv
// Package for the latching relay sequencer: phase codes, pin image bits,
// register indexes and reset values. No dependencies.
`default_nettype none
package lrs_pkg;

    localparam int unsigned CNT_W   = 15;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned PINS_W  = 4;

    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [PINS_W-1:0]  t_pins;

    localparam t_phase PH_INIT     = 3'd0;
    localparam t_phase PH_IDLE     = 3'd1;
    localparam t_phase PH_SW_OPEN  = 3'd2;
    localparam t_phase PH_HELD     = 3'd3;
    localparam t_phase PH_SW_BACK  = 3'd4;

    localparam t_pins PIN_COIL_A    = 4'b0001;
    localparam t_pins PIN_COIL_B    = 4'b0010;
    localparam t_pins PIN_LED_A     = 4'b0100;
    localparam t_pins PIN_LED_B     = 4'b1000;
    localparam t_pins PIN_BOTH_DARK = PIN_LED_A | PIN_LED_B;

    localparam logic REG_PULSE_TICKS = 1'b0;
    localparam logic REG_BLINK_HALF  = 1'b1;

    localparam t_count PULSE_TICKS_RST = 15'd999;
    localparam t_count BLINK_HALF_RST  = 15'd499;

endpackage
`default_nettype wire

// File: src/latching_relay_sequencer.sv
// Top level of the latching relay sequencer: phase machine, tick counter and
// result register. Depends on lrs_pkg.
//
// One item per clock while the input is not stalled: each accepted tick item
// updates phase, counter and pin image, and its result is loaded into the
// result register at the same clock edge, from the same next-state values.
// The only limit on rate is the single result register: input is stalled only
// while a result is waiting and the output side is stalling. Configuration
// writes take effect on the next accepted item.
`default_nettype none
module latching_relay_sequencer (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_index,
    input  wire  [14:0]           i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire                   i_ptt_pressed,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic                  o_coil_a_drive,
    output logic                  o_coil_b_drive,
    output logic                  o_led_a_off,
    output logic                  o_led_b_off,
    output lrs_pkg::t_phase       o_relay_phase
);
    import lrs_pkg::*;

    t_count r_pulse_ticks;
    t_count r_blink_half;
    t_phase r_phase, n_phase;
    t_count r_tick, n_tick;
    t_pins  r_pins, n_pins;
    logic   r_out_valid;
    t_pins  r_out_pins;
    t_phase r_out_phase;
    logic   in_accept;
    logic   below_half, below_lim;
    t_count tick_inc;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign below_half = r_tick < r_blink_half;
    assign below_lim  = r_tick < r_pulse_ticks;
    assign tick_inc   = r_tick + t_count'(1);

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_pins  = r_pins;
        unique case (r_phase)
            PH_IDLE: begin
                if (below_half) begin
                    n_tick = tick_inc;
                end else if (below_lim) begin
                    n_tick = tick_inc;
                    n_pins = r_pins & ~PIN_LED_A;
                end else begin
                    n_tick = '0;
                    n_pins = r_pins | PIN_LED_A;
                end
                if (i_ptt_pressed) begin
                    n_tick  = '0;
                    n_phase = PH_SW_OPEN;
                    n_pins  = n_pins | PIN_LED_A;
                end
            end
            PH_SW_OPEN: begin
                if (below_lim) begin
                    if (i_ptt_pressed) begin
                        n_tick = tick_inc;
                        n_pins = PIN_COIL_B | PIN_LED_A;
                    end else begin
                        n_tick  = '0;
                        n_phase = PH_SW_BACK;
                        n_pins  = PIN_BOTH_DARK;
                    end
                end else begin
                    n_tick  = '0;
                    n_pins  = (r_pins & ~PIN_COIL_B) | PIN_LED_B;
                    n_phase = i_ptt_pressed ? PH_HELD : PH_SW_BACK;
                end
            end
            PH_HELD: begin
                if (below_half) begin
                    if (i_ptt_pressed) begin
                        n_tick = tick_inc;
                    end else begin
                        n_tick  = '0;
                        n_phase = PH_SW_BACK;
                    end
                end else if (below_lim) begin
                    if (i_ptt_pressed) begin
                        n_tick = tick_inc;
                        n_pins = r_pins & ~PIN_LED_B;
                    end else begin
                        n_tick  = '0;
                        n_phase = PH_SW_BACK;
                        n_pins  = PIN_BOTH_DARK;
                    end
                end else begin
                    n_tick  = '0;
                    n_pins  = r_pins | PIN_LED_B;
                    n_phase = i_ptt_pressed ? PH_HELD : PH_SW_BACK;
                end
            end
            PH_SW_BACK: begin
                if (below_lim) begin
                    if (i_ptt_pressed) begin
                        n_tick  = '0;
                        n_phase = PH_SW_OPEN;
                        n_pins  = PIN_BOTH_DARK;
                    end else begin
                        n_tick = tick_inc;
                        n_pins = PIN_COIL_A | PIN_LED_B;
                    end
                end else begin
                    n_tick  = '0;
                    n_pins  = PIN_BOTH_DARK;
                    n_phase = i_ptt_pressed ? PH_SW_OPEN : PH_IDLE;
                end
            end
            default: begin
                if (below_lim) begin
                    n_tick  = tick_inc;
                    n_pins  = r_pins | PIN_COIL_A | PIN_LED_B;
                    n_phase = PH_INIT;
                end else begin
                    n_tick  = '0;
                    n_pins  = (r_pins & ~PIN_COIL_A) | PIN_LED_A;
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks <= PULSE_TICKS_RST;
            r_blink_half  <= BLINK_HALF_RST;
            r_phase       <= PH_INIT;
            r_tick        <= '0;
            r_pins        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PULSE_TICKS: r_pulse_ticks <= i_cfg_data;
                    REG_BLINK_HALF:  r_blink_half  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_pins  <= n_pins;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_pins  <= n_pins;
            r_out_phase <= n_phase;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_coil_a_drive = r_out_pins[0];
    assign o_coil_b_drive = r_out_pins[1];
    assign o_led_a_off    = r_out_pins[2];
    assign o_led_b_off    = r_out_pins[3];
    assign o_relay_phase  = r_out_phase;

endmodule
`default_nettype wire

// File: src/lrs_checker.sv
// Port-level checker for the latching relay sequencer and its bind.
// Depends on lrs_pkg and latching_relay_sequencer.
`default_nettype none
module lrs_checker (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   o_in_stall,
    input  wire                   o_out_valid,
    input  wire                   i_out_stall,
    input  wire                   o_coil_a_drive,
    input  wire                   o_coil_b_drive,
    input  wire lrs_pkg::t_phase  o_relay_phase
);
    import lrs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_relay_phase))
        else $error("result dropped while stalled");

    a_coils_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_coil_a_drive && o_coil_b_drive))
        else $error("both coils driven");

    a_steady_coils_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_relay_phase == PH_IDLE || o_relay_phase == PH_HELD)
            |-> !o_coil_a_drive && !o_coil_b_drive)
        else $error("coil driven in a steady phase");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted item produced no result");

endmodule

bind latching_relay_sequencer lrs_checker u_lrs_checker (.*);
`default_nettype wire

// File: verif/tb_latching_relay_sequencer.sv
// Testbench for latching_relay_sequencer: a scoreboard class predicts every tick
// result and checks it. Tasks drive ticks with random idling, and register writes.
// Depends on lrs_pkg and the block's top level.
`timescale 1ns / 100ps
`default_nettype none
module tb_latching_relay_sequencer;
    import lrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 60;
    localparam logic [0:21] DIRECTED_PTT = 22'b0000000011111101000000;

    typedef struct packed {
        logic   coil_a;
        logic   coil_b;
        logic   led_a_off;
        logic   led_b_off;
        t_phase phase;
    } t_relay_out;

    class t_relay_scoreboard;
        t_count     pulse_lim;
        t_count     blink_half;
        t_phase     phase;
        t_count     ticks;
        t_pins      pins;
        t_relay_out pending[$];
        int         errors;

        function new();
            pulse_lim  = PULSE_TICKS_RST;
            blink_half = BLINK_HALF_RST;
            phase      = PH_INIT;
            ticks      = '0;
            pins       = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic idx, t_count val);
            if (idx == REG_PULSE_TICKS) begin
                pulse_lim = val;
            end else begin
                blink_half = val;
            end
        endfunction

        function void note_tick(logic ptt);
            t_relay_out r;
            case (phase)
                PH_IDLE: begin
                    if (ticks < blink_half) begin
                        ticks = ticks + 1'b1;
                    end else if (ticks < pulse_lim) begin
                        ticks = ticks + 1'b1;
                        pins  = pins & ~PIN_LED_A;
                    end else begin
                        ticks = '0;
                        pins  = pins | PIN_LED_A;
                    end
                    if (ptt) begin
                        ticks = '0;
                        phase = PH_SW_OPEN;
                        pins  = pins | PIN_LED_A;
                    end
                end
                PH_SW_OPEN: begin
                    if (ticks < pulse_lim) begin
                        ticks = ticks + 1'b1;
                        pins  = PIN_COIL_B | PIN_LED_A;
                        if (!ptt) begin
                            ticks = '0;
                            phase = PH_SW_BACK;
                            pins  = PIN_BOTH_DARK;
                        end
                    end else begin
                        ticks = '0;
                        pins  = (pins & ~PIN_COIL_B) | PIN_LED_B;
                        phase = ptt ? PH_HELD : PH_SW_BACK;
                    end
                end
                PH_HELD: begin
                    if (ticks < blink_half) begin
                        ticks = ticks + 1'b1;
                        if (!ptt) begin
                            ticks = '0;
                            phase = PH_SW_BACK;
                        end
                    end else if (ticks < pulse_lim) begin
                        ticks = ticks + 1'b1;
                        if (ptt) begin
                            pins = pins & ~PIN_LED_B;
                        end else begin
                            ticks = '0;
                            phase = PH_SW_BACK;
                            pins  = PIN_BOTH_DARK;
                        end
                    end else begin
                        ticks = '0;
                        pins  = pins | PIN_LED_B;
                        phase = ptt ? PH_HELD : PH_SW_BACK;
                    end
                end
                PH_SW_BACK: begin
                    if (ticks < pulse_lim) begin
                        ticks = ticks + 1'b1;
                        pins  = PIN_COIL_A | PIN_LED_B;
                        if (ptt) begin
                            ticks = '0;
                            phase = PH_SW_OPEN;
                            pins  = PIN_BOTH_DARK;
                        end
                    end else begin
                        ticks = '0;
                        pins  = PIN_BOTH_DARK;
                        phase = ptt ? PH_SW_OPEN : PH_IDLE;
                    end
                end
                default: begin
                    if (ticks < pulse_lim) begin
                        ticks = ticks + 1'b1;
                        pins  = pins | PIN_COIL_A | PIN_LED_B;
                        phase = PH_INIT;
                    end else begin
                        ticks = '0;
                        pins  = (pins & ~PIN_COIL_A) | PIN_LED_A;
                        phase = PH_IDLE;
                    end
                end
            endcase
            r = '{pins[0], pins[1], pins[2], pins[3], phase};
            pending.push_back(r);
        endfunction

        function void check_result(t_relay_out got);
            t_relay_out want;
            if (pending.size() == 0) begin
                if (errors < 10) begin
                    $display("[%0t] unexpected result coil_a=%b coil_b=%b led_a=%b led_b=%b ph=%0d",
                             $realtime, got.coil_a, got.coil_b, got.led_a_off, got.led_b_off,
                             got.phase);
                end
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                if (errors < 10) begin
                    $display("[%0t] mismatch: exp coil_a=%b coil_b=%b led_a=%b led_b=%b ph=%0d",
                             $realtime, want.coil_a, want.coil_b, want.led_a_off,
                             want.led_b_off, want.phase);
                    $display("             got coil_a=%b coil_b=%b led_a=%b led_b=%b ph=%0d",
                             got.coil_a, got.coil_b, got.led_a_off, got.led_b_off, got.phase);
                end
                errors++;
            end
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_we;
    logic   i_cfg_index;
    logic   [14:0] i_cfg_data;
    logic   i_in_valid;
    logic   o_in_stall;
    logic   i_ptt_pressed;
    logic   o_out_valid;
    logic   i_out_stall;
    logic   o_coil_a_drive;
    logic   o_coil_b_drive;
    logic   o_led_a_off;
    logic   o_led_b_off;
    t_phase o_relay_phase;

    t_relay_scoreboard sb;
    bit calm = 1'b0;
    int n_results = 0;
    int idle_cycles = 0;

    latching_relay_sequencer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_ptt_pressed  (i_ptt_pressed),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_coil_a_drive (o_coil_a_drive),
        .o_coil_b_drive (o_coil_b_drive),
        .o_led_a_off    (o_led_a_off),
        .o_led_b_off    (o_led_b_off),
        .o_relay_phase  (o_relay_phase)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic send_tick(input logic ptt);
        if (!calm && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_ptt_pressed <= ptt;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_tick(ptt);
    endtask

    task automatic set_limits(input t_count pulse, input t_count half);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_PULSE_TICKS;
        i_cfg_data  <= pulse;
        @(posedge i_clk);
        sb.set_reg(REG_PULSE_TICKS, pulse);
        i_cfg_index <= REG_BLINK_HALF;
        i_cfg_data  <= half;
        @(posedge i_clk);
        sb.set_reg(REG_BLINK_HALF, half);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_count pulse, input t_count half, input int count);
        int   span;
        int   run_left;
        logic level;
        bit   noisy;
        drain_results();
        set_limits(pulse, half);
        span     = ((pulse > 20) ? 20 : int'(pulse)) * 2 + 4;
        run_left = 0;
        level    = 1'b1;
        noisy    = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (run_left == 0) begin
                level    = !level;
                run_left = $urandom_range(1, span);
                noisy    = ($urandom_range(0, 4) == 0);
            end
            run_left--;
            send_tick(noisy ? 1'($urandom_range(0, 1)) : level);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_PULSE_TICKS;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_ptt_pressed <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_limits(15'd3, 15'd1);
        for (int k = 0; k < 22; k++) begin
            send_tick(DIRECTED_PTT[k]);
        end

        run_phase(15'd6, 15'd3, 180);
        run_phase(15'd2, 15'd1, 150);
        run_phase(15'd1, 15'd0, 150);
        run_phase(15'd0, 15'd0, 120);
        run_phase(15'd4, 15'd4, 150);
        run_phase(15'd3, 15'd9, 150);
        run_phase(15'd12, 15'd5, 200);
        run_phase(15'd5, 15'd1, 150);
        run_phase(15'd32767, 15'd0, 60);
        run_phase(15'd32767, 15'd32767, 60);
        run_phase(15'd0, 15'd32767, 60);
        drain_results();
        calm = 1'b1;
        run_phase(15'd9, 15'd4, 200);

        drain_results();
        repeat (5) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        int  burst_left;
        int  hold_left;
        bit  long_done;
        burst_left = 0;
        hold_left  = 0;
        long_done  = 1'b0;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                sb.check_result('{o_coil_a_drive, o_coil_b_drive, o_led_a_off,
                                  o_led_b_off, o_relay_phase});
                n_results++;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!long_done && n_results >= 300) begin
                hold_left = LONG_HOLD;
                long_done = 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(1, 6);
            end
            i_out_stall <= (hold_left > 0 || burst_left > 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
`default_nettype wire

// File: files.f
src/lrs_pkg.sv
src/latching_relay_sequencer.sv
src/lrs_checker.sv
verif/tb_latching_relay_sequencer.sv
